/* rtl/cts_pkg.sv */
// ---------------------------------------------------------------------------
// cts_pkg
// Shared types, command codes and status codes of the cooperative task
// scheduler.
// ---------------------------------------------------------------------------
package cts_pkg;

  localparam int NUM_SLOTS_DEF = 8;
  localparam int MAX_RUNS      = 8;
  localparam int RUN_CNT_W     = $clog2(MAX_RUNS + 1);

  localparam logic [1:0] CMD_ADD  = 2'd0;
  localparam logic [1:0] CMD_DEL  = 2'd1;
  localparam logic [1:0] CMD_TICK = 2'd2;
  localparam logic [1:0] CMD_DISP = 2'd3;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_BAD   = 2'd2;
  localparam logic [1:0] STAT_NONE  = 2'd3;

  localparam logic [2:0] OP_ADD  = 3'd0;
  localparam logic [2:0] OP_DEL  = 3'd1;
  localparam logic [2:0] OP_BAD  = 3'd2;
  localparam logic [2:0] OP_TICK = 3'd3;
  localparam logic [2:0] OP_DISP = 3'd4;

  localparam logic [7:0] PEND_MAX = 8'hFF;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] task_tag;
    logic [15:0] first_delay;
    logic [15:0] repeat_period;
    logic [7:0]  target_slot;
  } cts_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [2:0]  slot_index;
    logic [15:0] run_tag;
    logic        run_now;
    logic        last;
  } cts_out_t;

  typedef struct packed {
    logic [2:0]  op;
    logic [15:0] tag;
    logic [15:0] delay;
    logic [15:0] period;
    logic [7:0]  slot;
  } cts_job_t;

  typedef struct packed {
    logic [15:0] tag;
    logic [15:0] delay;
    logic [15:0] period;
    logic [7:0]  pending;
  } cts_slot_t;

endpackage

/* rtl/cts_front.sv */
// ---------------------------------------------------------------------------
// cts_front
// Accepts input words, classifies the command (including the range check on
// delete) and queues the resulting job in a two-entry queue.
// ---------------------------------------------------------------------------
module cts_front #(
  parameter int NUM_SLOTS = cts_pkg::NUM_SLOTS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  cts_pkg::cts_in_t  in_data,
  output logic              job_valid,
  input  logic              job_ready,
  output cts_pkg::cts_job_t job
);

  cts_pkg::cts_job_t q_r [2];
  logic              wr_ptr_r;
  logic              rd_ptr_r;
  logic [1:0]        cnt_r;
  logic [1:0]        cnt_nxt;
  logic              push;
  logic              pop;
  cts_pkg::cts_job_t job_in;

  assign in_ready  = (cnt_r != 2'd2);
  assign job_valid = (cnt_r != 2'd0);
  assign job       = q_r[rd_ptr_r];
  assign push      = in_valid && in_ready;
  assign pop       = job_valid && job_ready;

  always_comb begin
    job_in.tag    = in_data.task_tag;
    job_in.delay  = in_data.first_delay;
    job_in.period = in_data.repeat_period;
    job_in.slot   = in_data.target_slot;
    case (in_data.cmd)
      cts_pkg::CMD_ADD:  job_in.op = cts_pkg::OP_ADD;
      cts_pkg::CMD_DEL: begin
        if (in_data.target_slot >= 8'(NUM_SLOTS)) job_in.op = cts_pkg::OP_BAD;
        else job_in.op = cts_pkg::OP_DEL;
      end
      cts_pkg::CMD_TICK: job_in.op = cts_pkg::OP_TICK;
      default:           job_in.op = cts_pkg::OP_DISP;
    endcase
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + 2'd1;
    else if (pop && !push) cnt_nxt = cnt_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (push) q_r[wr_ptr_r] <= job_in;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop) rd_ptr_r <= ~rd_ptr_r;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

/* rtl/cts_back.sv */
// ---------------------------------------------------------------------------
// cts_back
// Slot table and command sequencer. Works through the table memory one slot
// at a time and drives the registered result word.
// ---------------------------------------------------------------------------
module cts_back #(
  parameter int NUM_SLOTS = cts_pkg::NUM_SLOTS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              job_valid,
  output logic              job_ready,
  input  cts_pkg::cts_job_t job,
  output logic              out_valid,
  input  logic              out_ready,
  output cts_pkg::cts_out_t out_data
);

  localparam int SLOT_W = $clog2(NUM_SLOTS);
  localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(NUM_SLOTS - 1);
  localparam logic [cts_pkg::RUN_CNT_W-1:0] LAST_RUN =
    cts_pkg::RUN_CNT_W'(cts_pkg::MAX_RUNS - 1);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_ADD     = 4'd1;
  localparam logic [3:0] S_TICK_RD = 4'd2;
  localparam logic [3:0] S_TICK_EV = 4'd3;
  localparam logic [3:0] S_DSP_RD  = 4'd4;
  localparam logic [3:0] S_DSP_EV  = 4'd5;
  localparam logic [3:0] S_DSP_HIT = 4'd6;
  localparam logic [3:0] S_DSP_FIN = 4'd7;
  localparam logic [3:0] S_EMIT    = 4'd8;

  cts_pkg::cts_slot_t slot_mem_r [NUM_SLOTS];
  cts_pkg::cts_slot_t rd_data_r;
  logic               mem_we;
  logic               mem_re;
  logic [SLOT_W-1:0]  mem_waddr;
  logic [SLOT_W-1:0]  mem_raddr;
  cts_pkg::cts_slot_t mem_wdata;

  logic [3:0]                   state_r,      state_nxt;
  logic [SLOT_W-1:0]            idx_r,        idx_nxt;
  logic [SLOT_W-1:0]            ptr_r,        ptr_nxt;
  logic [cts_pkg::RUN_CNT_W-1:0] n_r,         n_nxt;
  logic [NUM_SLOTS-1:0]         used_r,       used_nxt;
  cts_pkg::cts_job_t            job_r,        job_nxt;
  cts_pkg::cts_out_t            res_r,        res_nxt;
  cts_pkg::cts_out_t            cand_r,       cand_nxt;
  cts_pkg::cts_out_t            hold_r,       hold_nxt;
  logic                         hold_valid_r, hold_valid_nxt;
  cts_pkg::cts_out_t            out_r,        out_nxt;
  logic                         out_valid_r,  out_valid_nxt;
  logic                         out_free;
  logic [SLOT_W-1:0]            del_idx;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign out_free  = !out_valid_r || out_ready;
  assign del_idx   = job.slot[SLOT_W-1:0];

  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    ptr_nxt        = ptr_r;
    n_nxt          = n_r;
    used_nxt       = used_r;
    job_nxt        = job_r;
    res_nxt        = res_r;
    cand_nxt       = cand_r;
    hold_nxt       = hold_r;
    hold_valid_nxt = hold_valid_r;
    out_nxt        = out_r;
    out_valid_nxt  = out_valid_r;
    mem_we         = 1'b0;
    mem_re         = 1'b0;
    mem_waddr      = idx_r;
    mem_raddr      = idx_r;
    mem_wdata      = rd_data_r;
    job_ready      = 1'b0;

    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;

    case (state_r)
      S_IDLE: begin
        job_ready = 1'b1;
        if (job_valid) begin
          job_nxt             = job;
          idx_nxt             = '0;
          n_nxt               = '0;
          res_nxt.status      = cts_pkg::STAT_OK;
          res_nxt.slot_index  = 3'd0;
          res_nxt.run_tag     = 16'd0;
          res_nxt.run_now     = 1'b0;
          res_nxt.last        = 1'b1;
          case (job.op)
            cts_pkg::OP_ADD:  state_nxt = S_ADD;
            cts_pkg::OP_DEL: begin
              used_nxt[del_idx]  = 1'b0;
              res_nxt.slot_index = 3'(del_idx);
              state_nxt          = S_EMIT;
            end
            cts_pkg::OP_BAD: begin
              res_nxt.status = cts_pkg::STAT_BAD;
              state_nxt      = S_EMIT;
            end
            cts_pkg::OP_TICK: state_nxt = S_TICK_RD;
            default:          state_nxt = S_DSP_RD;
          endcase
        end
      end
      S_ADD: begin
        if (!used_r[idx_r]) begin
          mem_we             = 1'b1;
          mem_waddr          = idx_r;
          mem_wdata.tag      = job_r.tag;
          mem_wdata.delay    = job_r.delay;
          mem_wdata.period   = job_r.period;
          mem_wdata.pending  = 8'd0;
          used_nxt[idx_r]    = 1'b1;
          res_nxt.slot_index = 3'(idx_r);
          state_nxt          = S_EMIT;
        end else if (idx_r == LAST_IDX) begin
          res_nxt.status = cts_pkg::STAT_FULL;
          state_nxt      = S_EMIT;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_TICK_RD: begin
        mem_re    = 1'b1;
        mem_raddr = ptr_r;
        state_nxt = S_TICK_EV;
      end
      S_TICK_EV: begin
        mem_waddr = ptr_r;
        if (used_r[ptr_r]) begin
          mem_we = 1'b1;
          if (rd_data_r.delay == 16'd0) begin
            if (rd_data_r.pending != cts_pkg::PEND_MAX)
              mem_wdata.pending = rd_data_r.pending + 8'd1;
            if (rd_data_r.period != 16'd0) mem_wdata.delay = rd_data_r.period;
          end else begin
            mem_wdata.delay = rd_data_r.delay - 16'd1;
          end
        end
        res_nxt.slot_index = 3'(ptr_r);
        ptr_nxt   = (ptr_r == LAST_IDX) ? '0 : ptr_r + 1'b1;
        state_nxt = S_EMIT;
      end
      S_DSP_RD: begin
        if (used_r[idx_r]) begin
          mem_re    = 1'b1;
          state_nxt = S_DSP_EV;
        end else if (idx_r == LAST_IDX) begin
          state_nxt = S_DSP_FIN;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_DSP_EV: begin
        if (rd_data_r.pending != 8'd0) begin
          mem_we            = 1'b1;
          mem_wdata.pending = rd_data_r.pending - 8'd1;
          if (rd_data_r.period == 16'd0) used_nxt[idx_r] = 1'b0;
          cand_nxt.status     = cts_pkg::STAT_OK;
          cand_nxt.slot_index = 3'(idx_r);
          cand_nxt.run_tag    = rd_data_r.tag;
          cand_nxt.run_now    = 1'b1;
          cand_nxt.last       = 1'b0;
          state_nxt           = S_DSP_HIT;
        end else if (idx_r == LAST_IDX) begin
          state_nxt = S_DSP_FIN;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = S_DSP_RD;
        end
      end
      S_DSP_HIT: begin
        if (!hold_valid_r || out_free) begin
          if (hold_valid_r) begin
            out_valid_nxt = 1'b1;
            out_nxt       = hold_r;
          end
          hold_nxt       = cand_r;
          hold_valid_nxt = 1'b1;
          n_nxt          = n_r + 1'b1;
          if (n_r == LAST_RUN || idx_r == LAST_IDX) begin
            state_nxt = S_DSP_FIN;
          end else begin
            idx_nxt   = idx_r + 1'b1;
            state_nxt = S_DSP_RD;
          end
        end
      end
      S_DSP_FIN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          if (hold_valid_r) begin
            out_nxt      = hold_r;
            out_nxt.last = 1'b1;
          end else begin
            out_nxt.status     = cts_pkg::STAT_NONE;
            out_nxt.slot_index = 3'd0;
            out_nxt.run_tag    = 16'd0;
            out_nxt.run_now    = 1'b0;
            out_nxt.last       = 1'b1;
          end
          hold_valid_nxt = 1'b0;
          state_nxt      = S_IDLE;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_nxt       = res_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) slot_mem_r[mem_waddr] <= mem_wdata;
    if (mem_re) rd_data_r <= slot_mem_r[mem_raddr];
  end

  always_ff @(posedge clk) begin
    idx_r  <= idx_nxt;
    n_r    <= n_nxt;
    job_r  <= job_nxt;
    res_r  <= res_nxt;
    cand_r <= cand_nxt;
    hold_r <= hold_nxt;
    out_r  <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      ptr_r        <= '0;
      used_r       <= '0;
      hold_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      ptr_r        <= ptr_nxt;
      used_r       <= used_nxt;
      hold_valid_r <= hold_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

endmodule

/* rtl/cooperative_task_scheduler.sv */
// ---------------------------------------------------------------------------
// cooperative_task_scheduler
// Time-triggered cooperative scheduler with a table of NUM_SLOTS task slots.
// ---------------------------------------------------------------------------
// Commands enter a two-entry job queue and are carried out one at a time by
// a sequencer that visits the table slots one at a time through a single-port
// slot memory with registered read; slot valid bits are flip-flops cleared
// by reset, so no clearing pass is needed. Add scans for the first free slot,
// tick services the slot at the tick pointer, and dispatch reads each
// occupied slot, ending after at most 8 dispatched tasks. The job queue
// registers each job before the sequencer takes it, and a result word held
// by the receiver stalls the sequencer until it is taken.
// Each result word carries last on the final word of a command.
// ---------------------------------------------------------------------------
module cooperative_task_scheduler #(
  parameter int NUM_SLOTS = cts_pkg::NUM_SLOTS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  cts_pkg::cts_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output cts_pkg::cts_out_t out_data
);

  logic              job_valid;
  logic              job_ready;
  cts_pkg::cts_job_t job;

  cts_front #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .job_valid (job_valid),
    .job_ready (job_ready),
    .job       (job)
  );

  cts_back #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (job_valid),
    .job_ready (job_ready),
    .job       (job),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

/* tb/tb_cooperative_task_scheduler.sv */
// ----------------------------------------------------------------------------
// tb_cooperative_task_scheduler
// Drives add, delete, tick and dispatch commands into the scheduler and
// checks every returned word against a cycle-free model of the slot table.
// Covers the empty table, a full table, bad indexes, one-shot and periodic
// tasks, pending accumulation, output back-pressure and random command mixes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_cooperative_task_scheduler;

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              in_valid  = 1'b0;
  logic              in_ready;
  cts_pkg::cts_in_t  in_data   = '0;
  logic              out_valid;
  logic              out_ready = 1'b1;
  cts_pkg::cts_out_t out_data;

  // table copy kept by the checker
  bit         tbl_used [cts_pkg::NUM_SLOTS_DEF];
  bit [15:0]  tbl_tag  [cts_pkg::NUM_SLOTS_DEF];
  bit [15:0]  tbl_delay[cts_pkg::NUM_SLOTS_DEF];
  bit [15:0]  tbl_period[cts_pkg::NUM_SLOTS_DEF];
  bit [7:0]   tbl_pend [cts_pkg::NUM_SLOTS_DEF];
  int         tick_ptr;

  cts_pkg::cts_out_t due_words[$];
  int         n_bad;
  bit         idle_on;
  int         hold_req;
  int         hold_cnt;

  cooperative_task_scheduler u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

  function automatic cts_pkg::cts_out_t mk_word(logic [1:0] st, int idx, logic [15:0] tag,
                                                logic run, logic lst);
    cts_pkg::cts_out_t w;
    w.status     = st;
    w.slot_index = idx[2:0];
    w.run_tag    = tag;
    w.run_now    = run;
    w.last       = lst;
    return w;
  endfunction

  function automatic void free_slot(int s);
    tbl_used[s]   = 1'b0;
    tbl_tag[s]    = '0;
    tbl_delay[s]  = '0;
    tbl_period[s] = '0;
    tbl_pend[s]   = '0;
  endfunction

  // update the table copy and queue the words this command must produce
  function automatic void apply_command(cts_pkg::cts_in_t c);
    int                s;
    int                hit;
    cts_pkg::cts_out_t runs[$];
    case (c.cmd)
      cts_pkg::CMD_ADD: begin
        hit = -1;
        for (s = 0; s < cts_pkg::NUM_SLOTS_DEF; s++) begin
          if (hit < 0 && !tbl_used[s]) hit = s;
        end
        if (hit < 0) begin
          due_words.push_back(mk_word(cts_pkg::STAT_FULL, 0, '0, 1'b0, 1'b1));
        end else begin
          tbl_used[hit]   = 1'b1;
          tbl_tag[hit]    = c.task_tag;
          tbl_delay[hit]  = c.first_delay;
          tbl_period[hit] = c.repeat_period;
          tbl_pend[hit]   = '0;
          due_words.push_back(mk_word(cts_pkg::STAT_OK, hit, '0, 1'b0, 1'b1));
        end
      end
      cts_pkg::CMD_DEL: begin
        if (c.target_slot >= cts_pkg::NUM_SLOTS_DEF) begin
          due_words.push_back(mk_word(cts_pkg::STAT_BAD, 0, '0, 1'b0, 1'b1));
        end else begin
          free_slot(c.target_slot);
          due_words.push_back(mk_word(cts_pkg::STAT_OK, c.target_slot, '0, 1'b0, 1'b1));
        end
      end
      cts_pkg::CMD_TICK: begin
        s = tick_ptr;
        if (tbl_used[s]) begin
          if (tbl_delay[s] == 0) begin
            if (tbl_pend[s] != cts_pkg::PEND_MAX) tbl_pend[s]++;
            if (tbl_period[s] != 0) tbl_delay[s] = tbl_period[s];
          end else begin
            tbl_delay[s]--;
          end
        end
        due_words.push_back(mk_word(cts_pkg::STAT_OK, s, '0, 1'b0, 1'b1));
        tick_ptr = (s + 1) % cts_pkg::NUM_SLOTS_DEF;
      end
      default: begin
        for (s = 0; s < cts_pkg::NUM_SLOTS_DEF && runs.size() < cts_pkg::MAX_RUNS; s++) begin
          if (tbl_used[s] && tbl_pend[s] != 0) begin
            runs.push_back(mk_word(cts_pkg::STAT_OK, s, tbl_tag[s], 1'b1, 1'b0));
            tbl_pend[s]--;
            if (tbl_period[s] == 0) free_slot(s);
          end
        end
        if (runs.size() == 0) begin
          due_words.push_back(mk_word(cts_pkg::STAT_NONE, 0, '0, 1'b0, 1'b1));
        end else begin
          runs[runs.size()-1].last = 1'b1;
          foreach (runs[i]) due_words.push_back(runs[i]);
        end
      end
    endcase
  endfunction

  // valid stays high outside idle gaps: back-to-back words need no reassignment
  task automatic send_word(input cts_pkg::cts_in_t w);
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    apply_command(w);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
  endtask

  task automatic send_cmd(input logic [1:0] cmd, input logic [15:0] tag,
                          input logic [15:0] dly, input logic [15:0] per,
                          input logic [7:0] tgt);
    cts_pkg::cts_in_t w;
    w.cmd           = cmd;
    w.task_tag      = tag;
    w.first_delay   = dly;
    w.repeat_period = per;
    w.target_slot   = tgt;
    send_word(w);
  endtask

  task automatic wait_drained;
    in_valid <= 1'b0;
    while (due_words.size() != 0) @(posedge clk);
  endtask

  function automatic cts_pkg::cts_in_t random_cmd();
    cts_pkg::cts_in_t w;
    int               r;
    r = $urandom_range(0, 99);
    w.cmd = (r < 22) ? cts_pkg::CMD_ADD : (r < 35) ? cts_pkg::CMD_DEL :
            (r < 75) ? cts_pkg::CMD_TICK : cts_pkg::CMD_DISP;
    w.task_tag      = 16'($urandom_range(0, 65535));
    w.first_delay   = 16'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535)
                                                      : $urandom_range(0, 3));
    w.repeat_period = 16'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535)
                                                      : $urandom_range(0, 3));
    w.target_slot   = 8'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 255)
                                                     : $urandom_range(0, 7));
    return w;
  endfunction

  // receiver: random stalls, plus long hold-offs on request
  always begin
    @(posedge clk);
    if (hold_req > 0) begin
      hold_cnt = hold_req;
      hold_req = 0;
      out_ready <= 1'b0;
      while (hold_cnt > 0) begin
        @(posedge clk);
        hold_cnt--;
      end
      out_ready <= 1'b1;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      out_ready <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (due_words.size() == 0) begin
        n_bad++;
        if (n_bad <= 10)
          $display("ERROR: unexpected word st=%0d idx=%0d tag=%h run=%b last=%b",
                   out_data.status, out_data.slot_index, out_data.run_tag,
                   out_data.run_now, out_data.last);
      end else begin
        if (out_data.status !== due_words[0].status ||
            out_data.slot_index !== due_words[0].slot_index ||
            out_data.run_tag !== due_words[0].run_tag ||
            out_data.run_now !== due_words[0].run_now ||
            out_data.last !== due_words[0].last) begin
          n_bad++;
          if (n_bad <= 10)
            $display({"ERROR: exp st=%0d idx=%0d tag=%h run=%b last=%b, ",
                      "got st=%0d idx=%0d tag=%h run=%b last=%b"},
                     due_words[0].status, due_words[0].slot_index,
                     due_words[0].run_tag, due_words[0].run_now, due_words[0].last,
                     out_data.status, out_data.slot_index, out_data.run_tag,
                     out_data.run_now, out_data.last);
        end
        void'(due_words.pop_front());
      end
    end
  end

  task automatic test_empty_table;
    send_cmd(cts_pkg::CMD_DISP, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF);
    send_cmd(cts_pkg::CMD_TICK, '0, '0, '0, '0);
  endtask

  task automatic test_fill_table;
    send_cmd(cts_pkg::CMD_ADD, 16'h0000, 16'h0000, 16'h0000, 8'h00);
    send_cmd(cts_pkg::CMD_ADD, 16'hFFFF, 16'h0000, 16'h0001, 8'hFF);
    send_cmd(cts_pkg::CMD_ADD, 16'h5A5A, 16'h0001, 16'hFFFF, 8'h00);
    send_cmd(cts_pkg::CMD_ADD, 16'hA5A5, 16'hFFFF, 16'h0000, 8'h00);
    send_cmd(cts_pkg::CMD_ADD, 16'h1234, 16'h0000, 16'h0002, 8'h00);
    send_cmd(cts_pkg::CMD_ADD, 16'h8001, 16'h0000, 16'h0000, 8'h00);
    send_cmd(cts_pkg::CMD_ADD, 16'h7FFE, 16'h0002, 16'h0001, 8'h00);
    send_cmd(cts_pkg::CMD_ADD, 16'hC3C3, 16'h0000, 16'h0003, 8'h00);
    send_cmd(cts_pkg::CMD_ADD, 16'hBEEF, 16'h0000, 16'h0000, 8'h00);
  endtask

  task automatic test_delete;
    send_cmd(cts_pkg::CMD_DEL, '0, '0, '0, 8'd2);
    send_cmd(cts_pkg::CMD_DEL, '0, '0, '0, 8'd2);
    send_cmd(cts_pkg::CMD_DEL, '0, '0, '0, 8'd8);
    send_cmd(cts_pkg::CMD_DEL, '0, '0, '0, 8'hFF);
    send_cmd(cts_pkg::CMD_ADD, 16'h0F0F, 16'h0000, 16'h0000, 8'h00);
  endtask

  task automatic test_tick_dispatch;
    repeat (8) send_cmd(cts_pkg::CMD_TICK, '0, '0, '0, '0);
    send_cmd(cts_pkg::CMD_DISP, '0, '0, '0, '0);
    send_cmd(cts_pkg::CMD_DISP, '0, '0, '0, '0);
  endtask

  // slot 0 only, reloading every other service: runs pile up between dispatches
  task automatic test_pending_count;
    for (int s = 0; s < cts_pkg::NUM_SLOTS_DEF; s++)
      send_cmd(cts_pkg::CMD_DEL, '0, '0, '0, s[7:0]);
    send_cmd(cts_pkg::CMD_ADD, 16'h4242, 16'h0000, 16'h0001, 8'h00);
    repeat (24) send_cmd(cts_pkg::CMD_TICK, '0, '0, '0, '0);
    repeat (3) send_cmd(cts_pkg::CMD_DISP, '0, '0, '0, '0);
    send_cmd(cts_pkg::CMD_DEL, '0, '0, '0, 8'd0);
  endtask

  task automatic test_backpressure;
    wait_drained();
    hold_req = 300;
    repeat (6) send_cmd(cts_pkg::CMD_ADD, 16'($urandom_range(0, 65535)), 16'h0000,
                        16'h0001, 8'h00);
    repeat (8) send_cmd(cts_pkg::CMD_TICK, '0, '0, '0, '0);
    repeat (4) send_cmd(cts_pkg::CMD_DISP, '0, '0, '0, '0);
    wait_drained();
  endtask

  task automatic test_random_mix;
    for (int i = 0; i < 40; i++) begin
      if (i == 20) wait_drained();
      if (i == 30) idle_on = 1'b0;
      send_word(random_cmd());
    end
  endtask

  initial begin
    n_bad    = 0;
    tick_ptr = 0;
    hold_req = 0;
    idle_on  = 1'b1;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_empty_table();
    test_fill_table();
    test_delete();
    test_tick_dispatch();
    idle_on = 1'b0;
    test_pending_count();
    idle_on = 1'b1;
    test_backpressure();
    test_random_mix();
    wait_drained();
    repeat (60) @(posedge clk);
    if (n_bad == 0 && due_words.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/cts_pkg.sv
rtl/cts_front.sv
rtl/cts_back.sv
rtl/cooperative_task_scheduler.sv
tb/tb_cooperative_task_scheduler.sv
